/* design/svs_pkg.sv */
// shared types and constants for the staggered grid velocity sampler
// no dependencies
package svs_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic signed [40:0] HALF_Q16 = 41'sd32768;
    localparam logic [16:0]        ONE_Q16  = 17'd65536;
    localparam logic signed [65:0] ROUND_HALF = 66'sd2147483648;
    localparam logic signed [33:0] SAT_MAX  = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN  = -34'sd2147483648;

    // one classified request between front and back
    typedef struct packed {
        logic               is_sample;
        logic               wr_ok;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [39:0] gx;
        logic signed [39:0] gy;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_ADDR,
        BS_LO,
        BS_HI,
        BS_ACC,
        BS_RND
    } t_bstate;

endpackage

/* design/svs_fifo.sv */
// two-entry request queue between front and back
// depends on svs_pkg
module svs_fifo
    import svs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);
    t_cmd       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_ent[r_rp];
    assign w_push = i_push_valid & o_push_ready;
    assign w_pop  = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_ent[r_wp] <= i_push_cmd;
    end
endmodule

/* design/svs_front.sv */
// front end: input register, position scaling and request classification
// depends on svs_pkg
module svs_front
    import svs_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic signed [31:0] i_vel_x_in,
    input  logic signed [31:0] i_vel_y_in,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [23:0]        i_inv_cell_size,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output t_cmd               o_push_cmd
);
    logic               r_v;
    logic               r_op;
    logic [5:0]         r_cx, r_cy;
    logic signed [31:0] r_vx, r_vy, r_px, r_py;
    logic signed [55:0] w_prod_x, w_prod_y;
    logic               w_take;

    assign o_stall      = r_v & ~i_push_ready;
    assign w_take       = i_valid & ~o_stall;
    assign o_push_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (i_push_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= i_opcode;
            r_cx <= i_cell_x;
            r_cy <= i_cell_y;
            r_vx <= i_vel_x_in;
            r_vy <= i_vel_y_in;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    // scale to grid units, floor of q.16 product
    assign w_prod_x = 56'(r_px * $signed({1'b0, i_inv_cell_size}));
    assign w_prod_y = 56'(r_py * $signed({1'b0, i_inv_cell_size}));

    always_comb begin
        o_push_cmd.is_sample = (r_op == OP_SAMPLE);
        o_push_cmd.wr_ok     = (11'(r_cx) < 11'(GRID_WIDTH)) &&
                               (11'(r_cy) < 11'(GRID_HEIGHT));
        o_push_cmd.cell_x    = r_cx;
        o_push_cmd.cell_y    = r_cy;
        o_push_cmd.vel_x     = r_vx;
        o_push_cmd.vel_y     = r_vy;
        o_push_cmd.gx        = w_prod_x[55:16];
        o_push_cmd.gy        = w_prod_y[55:16];
    end
endmodule

/* design/svs_back.sv */
// back end: velocity stores and the per-corner interpolation sequencer
// depends on svs_pkg
module svs_back
    import svs_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  t_cmd               i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_vel_u,
    output logic signed [31:0] o_vel_v
);
    localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

    logic signed [31:0] r_mem_u [GRID_WIDTH * GRID_HEIGHT];
    logic signed [31:0] r_mem_v [GRID_WIDTH * GRID_HEIGHT];

    t_bstate            r_state, n_state;
    logic [2:0]         r_tap;
    logic signed [39:0] r_gx, r_gy;
    logic [32:0]        r_w;
    logic               r_in;
    logic signed [31:0] r_rd_u, r_rd_v;
    logic signed [48:0] r_plo;
    logic signed [49:0] r_phi;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_u;
    logic               r_ovalid;
    logic signed [31:0] r_ou, r_ov;

    logic               w_pop, w_wr_en, w_rd_en, w_comp, w_dx, w_dy, w_out_free;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic signed [40:0] w_bx, w_by;
    logic signed [25:0] w_col, w_row;
    logic [16:0]        w_wx, w_wy;
    logic [33:0]        w_wt;
    logic signed [31:0] w_data;
    logic signed [65:0] w_rs;
    logic signed [33:0] w_t;
    logic signed [31:0] w_sat;

    assign o_valid    = r_ovalid;
    assign o_vel_u    = r_ou;
    assign o_vel_v    = r_ov;
    assign w_out_free = ~r_ovalid | ~i_stall;

    // tap order: corner in bits 1:0, component in bit 2
    assign w_comp = r_tap[2];
    assign w_dx   = r_tap[0];
    assign w_dy   = r_tap[1];
    assign w_bx   = w_comp ? (41'(r_gx) - HALF_Q16) : 41'(r_gx);
    assign w_by   = w_comp ? 41'(r_gy) : (41'(r_gy) - HALF_Q16);
    // cell index is signed, so a left or lower neighbour of -1 still steps to 0
    assign w_col  = 26'($signed(w_bx[40:16])) + 26'(w_dx);
    assign w_row  = 26'($signed(w_by[40:16])) + 26'(w_dy);
    assign w_wx   = w_dx ? {1'b0, w_bx[15:0]} : ONE_Q16 - {1'b0, w_bx[15:0]};
    assign w_wy   = w_dy ? {1'b0, w_by[15:0]} : ONE_Q16 - {1'b0, w_by[15:0]};
    assign w_wt   = 34'(w_wx) * 34'(w_wy);
    assign w_raddr = AW'(w_row) * AW'(GRID_WIDTH) + AW'(w_col);
    assign w_waddr = AW'(i_cmd.cell_y) * AW'(GRID_WIDTH) + AW'(i_cmd.cell_x);

    assign w_data = r_in ? (w_comp ? r_rd_v : r_rd_u) : 32'sd0;

    // round half up, then clamp
    assign w_rs = r_acc + ROUND_HALF;
    assign w_t  = w_rs[65:32];
    always_comb begin
        if (w_t > SAT_MAX)      w_sat = SAT_MAX[31:0];
        else if (w_t < SAT_MIN) w_sat = SAT_MIN[31:0];
        else                    w_sat = w_t[31:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (w_pop && i_cmd.is_sample) n_state = BS_ADDR;
            BS_ADDR: n_state = BS_LO;
            BS_LO:   n_state = BS_HI;
            BS_HI:   n_state = BS_ACC;
            BS_ACC:  n_state = (r_tap[1:0] == 2'd3) ? BS_RND : BS_ADDR;
            BS_RND: begin
                if (!w_comp)         n_state = BS_ADDR;
                else if (w_out_free) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready = (r_state == BS_IDLE);
        w_rd_en     = (r_state == BS_ADDR);
        w_pop       = o_pop_ready & i_pop_valid;
        w_wr_en     = w_pop & ~i_cmd.is_sample & i_cmd.wr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_tap    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_IDLE) r_tap <= 3'd0;
            else if (r_state == BS_ACC && r_tap[1:0] != 2'd3) r_tap <= r_tap + 3'd1;
            else if (r_state == BS_RND && !w_comp) r_tap <= 3'd4;
            if (r_state == BS_RND && w_comp && w_out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_gx <= i_cmd.gx;
            r_gy <= i_cmd.gy;
        end
        unique case (r_state)
            BS_IDLE: r_acc <= '0;
            BS_ADDR: begin
                r_w  <= w_wt[32:0];
                r_in <= !w_col[25] && (w_col < 26'(GRID_WIDTH)) &&
                        !w_row[25] && (w_row < 26'(GRID_HEIGHT));
            end
            BS_LO: r_plo <= 49'(w_data * $signed({1'b0, r_w[15:0]}));
            BS_HI: begin
                r_phi <= 50'(w_data * $signed({1'b0, r_w[32:16]}));
                r_acc <= r_acc + 66'(r_plo);
            end
            BS_ACC: r_acc <= r_acc + (66'(r_phi) <<< 16);
            BS_RND: begin
                if (!w_comp) begin
                    r_u   <= w_sat;
                    r_acc <= '0;
                end else if (w_out_free) begin
                    r_ou <= r_u;
                    r_ov <= w_sat;
                end
            end
            default: r_acc <= '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_u[w_waddr] <= i_cmd.vel_x;
            r_mem_v[w_waddr] <= i_cmd.vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_u <= r_mem_u[w_raddr];
            r_rd_v <= r_mem_v[w_raddr];
        end
    end
endmodule

/* design/staggered_grid_velocity_sampler_unit.sv */
// top level of the staggered grid velocity sampler: config register and wiring
// depends on svs_pkg, svs_front, svs_fifo, svs_back
//
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_opcode .. i_pos_y
// result    out        o_valid / i_stall      o_vel_u, o_vel_v
// config    in         psel/penable/pready    paddr, pwdata, prdata
//
// a write is stored when the back end takes it from the queue; a sample walks
// eight taps, four corners per component, one at a time via narrow split multiplies
// the front scales registered positions and a two-entry queue decouples it
// synchronous active-low reset clears control state; store contents are undefined
// until written. input stall rises only when the front register and queue are full
module staggered_grid_velocity_sampler_unit
    import svs_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic signed [31:0] i_vel_x_in,
    input  logic signed [31:0] i_vel_y_in,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_vel_u,
    output logic signed [31:0] o_vel_v,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [23:0] r_inv;
    logic        w_cfg_wr;
    logic        w_push_v, w_push_rdy, w_pop_v, w_pop_rdy;
    t_cmd        w_push_cmd, w_pop_cmd;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {8'd0, r_inv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 24'd65536;
        end else if (w_cfg_wr) begin
            r_inv <= pwdata[23:0];
        end
    end

    svs_front #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_vel_x_in(i_vel_x_in), .i_vel_y_in(i_vel_y_in),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_inv_cell_size(r_inv),
        .o_push_valid(w_push_v), .i_push_ready(w_push_rdy), .o_push_cmd(w_push_cmd)
    );

    svs_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(w_push_v), .o_push_ready(w_push_rdy), .i_push_cmd(w_push_cmd),
        .o_pop_valid(w_pop_v), .i_pop_ready(w_pop_rdy), .o_pop_cmd(w_pop_cmd)
    );

    svs_back #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pop_valid(w_pop_v), .o_pop_ready(w_pop_rdy), .i_cmd(w_pop_cmd),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_vel_u(o_vel_u), .o_vel_v(o_vel_v)
    );

    // a full queue must hold the input side
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_v && !w_push_rdy) |-> o_stall)
        else $error("queue full without input stall");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_inv == $past(pwdata[23:0])))
        else $error("config write lost");

    // back end takes no request while a sample is in flight
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_v && w_pop_rdy && w_pop_cmd.is_sample) |=> !w_pop_rdy)
        else $error("request taken during a sample");
endmodule
